[design/interval_set_union_difference_defines.svh]
// Assertion macros used by the checker file.
`ifndef INTERVAL_SET_UNION_DIFFERENCE_DEFINES_SVH
`define INTERVAL_SET_UNION_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define ISUD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isud check failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define ISUD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isud check failed");

`endif

[design/isud_pkg.sv]
`default_nettype none
package isud_pkg;
	localparam int DEF_MAX_INTERVALS = 16;
	localparam int TW = 20;
	localparam logic [TW-1:0] WEEK_SECONDS = TW'(7 * 24 * 60 * 60);

	localparam logic OP_UNITE = 1'b0;
	localparam logic OP_SUB   = 1'b1;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [TW-1:0] s;
		logic [TW-1:0] e;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINAL,
		ST_COMMIT,
		ST_EMIT,
		ST_ALIGN
	} state_t;
endpackage
`default_nettype wire

[design/isud_cell.sv]
`default_nettype none
module isud_cell (
	input  wire logic            clk,
	input  wire isud_pkg::cell_ctl_t ctl,
	input  wire isud_pkg::entry_t nbr,
	input  wire isud_pkg::entry_t ld_data,
	output isud_pkg::entry_t     q
);
	import isud_pkg::*;

	entry_t val_q;

	// load wins over shift; hold otherwise
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= ld_data;
		end else if (ctl.shift) begin
			val_q <= nbr;
		end
	end

	assign q = val_q;
endmodule
`default_nettype wire

[design/interval_set_union_difference.sv]
// Disjoint interval set over one week. The set lives in a ring of MAX_INTERVALS
// cells; cell 0 is the head. An input word (s_tdata: op, new_start, new_end)
// is taken only when the block is idle. It then rotates the ring once round,
// feeding each held interval through a merge/split unit that writes the new
// list into a scratch row, places the new interval and commits in its FINAL
// and COMMIT states, and streams the set from the head cell, one word per
// accepted output cycle, rotating the ring as it goes. Any rotation left over
// after the last word is made up before the next input is taken. A bad
// interval leaves the set alone and reports status 1; a result that would
// not fit leaves it alone with status 2.
`default_nettype none
module interval_set_union_difference #(
	parameter int MAX_INTERVALS = isud_pkg::DEF_MAX_INTERVALS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // op[0], new_start[20:1], new_end[40:21], zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // seg_start[19:0], seg_end[39:20]
	output logic [2:0]       m_tuser,  // status[1:0], set_empty[2]
	output logic             m_tlast
);
	import isud_pkg::*;

	localparam int CW = $clog2(MAX_INTERVALS + 3);
	localparam logic [CW-1:0] MAXC  = CW'(MAX_INTERVALS);
	localparam logic [CW-1:0] LASTK = CW'(MAX_INTERVALS - 1);

	state_t        state_q, state_d;
	entry_t        cell_d [MAX_INTERVALS];
	entry_t        tmp_q  [MAX_INTERVALS];
	cell_ctl_t     ctl;
	logic [CW-1:0] count_q, n_q, k_q;
	logic          op_q, placed_q;
	logic [TW-1:0] ws_q, we_q;
	logic [1:0]    status_q;

	logic          in_op, in_bad, out_fire, is_last, commit_ok;
	logic [TW-1:0] in_s, in_e, a, b;
	logic          p0v, p1v, nplaced;
	entry_t        p0, p1;
	logic [TW-1:0] nws, nwe;
	logic          walk_live;

	assign in_op  = s_tdata[0];
	assign in_s   = s_tdata[20:1];
	assign in_e   = s_tdata[40:21];
	assign in_bad = (in_s >= in_e) || (in_e > WEEK_SECONDS);

	// ring of cells: each takes its upper neighbour, the top one wraps the head
	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		isud_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.nbr     (cell_d[(i + 1) % MAX_INTERVALS]),
			.ld_data (tmp_q[i]),
			.q       (cell_d[i])
		);
	end

	assign a = cell_d[0].s;
	assign b = cell_d[0].e;
	assign walk_live = (state_q == ST_WALK) && (k_q < count_q);

	// merge/split unit: one held interval per cycle, up to two words pushed
	always_comb begin
		p0v = 1'b0;
		p1v = 1'b0;
		p0 = cell_d[0];
		p1 = cell_d[0];
		nws = ws_q;
		nwe = we_q;
		nplaced = placed_q;
		if (op_q == OP_UNITE) begin
			if (b < ws_q) begin
				p0v = 1'b1;
			end else if (a > we_q) begin
				if (!placed_q) begin
					p0v = 1'b1;
					p0 = '{s: ws_q, e: we_q};
					p1v = 1'b1;
					nplaced = 1'b1;
				end else begin
					p0v = 1'b1;
				end
			end else begin
				// overlap or touch: widen the working interval
				if (a < ws_q) nws = a;
				if (b > we_q) nwe = b;
			end
		end else begin
			if ((b <= ws_q) || (a >= we_q)) begin
				p0v = 1'b1;
			end else begin
				if (a < ws_q) begin
					p0v = 1'b1;
					p0 = '{s: a, e: ws_q};
				end
				if (we_q < b) begin
					if (a < ws_q) begin
						p1v = 1'b1;
						p1 = '{s: we_q, e: b};
					end else begin
						p0v = 1'b1;
						p0 = '{s: we_q, e: b};
					end
				end
			end
		end
		// the final placement of a union reuses the first push slot
		if (state_q == ST_FINAL) begin
			p0v = (op_q == OP_UNITE) && !placed_q;
			p0 = '{s: ws_q, e: we_q};
			p1v = 1'b0;
		end
	end

	assign commit_ok = (n_q <= MAXC);
	assign out_fire  = m_tvalid && m_tready;
	assign is_last   = (count_q == '0) || (k_q == count_q - CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = in_bad ? ST_EMIT : ST_WALK;
			end
			ST_WALK: begin
				if (k_q == LASTK) state_d = ST_FINAL;
			end
			ST_FINAL:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_fire && is_last) begin
					if ((count_q == '0) || (k_q == LASTK)) state_d = ST_IDLE;
					else state_d = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (k_q == LASTK) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and ring control
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		ctl = '{shift: 1'b0, load: 1'b0};
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_WALK:   ctl.shift = 1'b1;
			ST_COMMIT: ctl.load = commit_ok;
			ST_EMIT: begin
				m_tvalid = 1'b1;
				ctl.shift = out_fire && (count_q != '0);
			end
			ST_ALIGN:  ctl.shift = 1'b1;
			default: ;
		endcase
	end

	assign m_tdata = (count_q == '0) ? '0 : {cell_d[0].e, cell_d[0].s};
	assign m_tuser = {count_q == '0, status_q};
	assign m_tlast = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			n_q      <= '0;
			k_q      <= '0;
			placed_q <= 1'b0;
			status_q <= STAT_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					n_q <= '0;
					placed_q <= 1'b0;
					if (s_tvalid) status_q <= in_bad ? STAT_BAD : STAT_OK;
				end
				ST_WALK: begin
					k_q <= k_q + CW'(1);
					if (walk_live) begin
						placed_q <= nplaced;
						// stop counting once overflow is certain
						if (n_q <= MAXC) n_q <= n_q + CW'(p0v) + CW'(p1v);
					end
				end
				ST_FINAL: begin
					k_q <= '0;
					if (p0v && (n_q <= MAXC)) n_q <= n_q + CW'(1);
				end
				ST_COMMIT: begin
					if (commit_ok) begin
						count_q <= n_q;
						status_q <= STAT_OK;
					end else begin
						status_q <= STAT_FULL;
					end
				end
				ST_EMIT: begin
					if (out_fire) k_q <= k_q + CW'(1);
				end
				ST_ALIGN: k_q <= k_q + CW'(1);
				default: ;
			endcase
		end
	end

	// payload: working interval and scratch row
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q <= in_op;
			ws_q <= in_s;
			we_q <= in_e;
		end else if (walk_live) begin
			ws_q <= nws;
			we_q <= nwe;
		end
		if (walk_live || state_q == ST_FINAL) begin
			for (int j = 0; j < MAX_INTERVALS; j++) begin
				if (p0v && (CW'(j) == n_q)) tmp_q[j] <= p0;
				if (p1v && (CW'(j) == n_q + CW'(1))) tmp_q[j] <= p1;
			end
		end
	end
endmodule
`default_nettype wire

[design/isud_checker.sv]
`default_nettype none
`include "interval_set_union_difference_defines.svh"
module isud_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);
	// a stalled result word holds
	`ISUD_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// an empty set is a single zero word
	`ISUD_ASSERT_IMP(a_empty, m_tvalid && m_tuser[2], m_tlast && (m_tdata == 40'd0))
	// status is never the unused code
	`ISUD_ASSERT_IMP(a_stat, m_tvalid, m_tuser[1:0] != 2'd3)
	// no input is taken while a run is out
	`ISUD_ASSERT_IMP(a_seq, s_tready, !m_tvalid)
	// a run ends cleanly
	`ISUD_ASSERT_NXT(a_end, m_tvalid && m_tready && m_tlast, !m_tvalid)
endmodule

bind interval_set_union_difference isud_checker u_isud_checker (.*);
`default_nettype wire
